### rtl/lrp_pkg.sv
// Package: shared types, character codes and the decimal step for the group list line parser.
`timescale 1ns / 1ps

package lrp_pkg;

    localparam int NAME_CAPACITY_DEF = 64;
    localparam int NUM_W             = 31;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_UPPER_X = 8'h58;
    localparam logic [7:0] CH_LOWER_X = 8'h78;
    localparam logic [7:0] CH_UPPER_Y = 8'h59;
    localparam logic [7:0] CH_LOWER_Y = 8'h79;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam logic [NUM_W-1:0] NUM_MAX = {NUM_W{1'b1}};

    typedef enum logic [2:0] {
        POS_NAME  = 3'd0,
        POS_LAST  = 3'd1,
        POS_FIRST = 3'd2,
        POS_FLAG  = 3'd3,
        POS_DONE  = 3'd4
    } pos_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_MISSING  = 2'd1,
        ST_REJECT   = 2'd2,
        ST_NONDIGIT = 2'd3
    } status_t;

    typedef enum logic {
        KIND_NAME    = 1'b0,
        KIND_SUMMARY = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t            kind;
        logic [7:0]       name_byte;
        logic [NUM_W-1:0] last_article;
        logic [NUM_W-1:0] first_article;
        logic             direct_post;
        status_t          line_status;
    } result_t;

    // acc * 10 + digit, saturated at the field maximum
    function automatic logic [NUM_W-1:0] dec_step(input logic [NUM_W-1:0] acc,
                                                  input logic [3:0] digit);
        logic [NUM_W+3:0] sum;
        sum = {acc, 3'b000} + {2'b00, acc, 1'b0} + {{NUM_W{1'b0}}, digit};
        if (sum > {4'b0000, NUM_MAX}) begin
            return NUM_MAX;
        end
        return sum[NUM_W-1:0];
    endfunction

endpackage

### rtl/lrp_parse.sv
// Parser state and per-byte update: field tracking, name emission, number accumulation.
`timescale 1ns / 1ps

module lrp_parse #(
    parameter int NAME_CAPACITY = lrp_pkg::NAME_CAPACITY_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             req_take,
    input  logic [7:0]       req_byte,
    input  logic             req_eol,
    output logic             res_valid,
    output lrp_pkg::result_t res
);

    localparam int LEN_W = (NAME_CAPACITY > 2) ? $clog2(NAME_CAPACITY) : 1;
    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(NAME_CAPACITY - 1);

    lrp_pkg::pos_t                pos_reg, pos_next;
    logic [LEN_W-1:0]             len_reg, len_next;
    logic [lrp_pkg::NUM_W-1:0]    last_reg, last_next;
    logic [lrp_pkg::NUM_W-1:0]    first_reg, first_next;
    logic                         post_reg, post_next;
    lrp_pkg::status_t             err_reg, err_next;

    logic is_delim;
    logic is_digit;

    assign is_delim = (req_byte == lrp_pkg::CH_SPACE) || (req_byte == lrp_pkg::CH_TAB);
    assign is_digit = (req_byte >= lrp_pkg::CH_ZERO) && (req_byte <= lrp_pkg::CH_NINE);

    // Field position
    always_comb begin
        pos_next = pos_reg;
        if (req_take) begin
            if (req_eol) begin
                pos_next = lrp_pkg::POS_NAME;
            end else begin
                unique case (pos_reg)
                    lrp_pkg::POS_NAME:  if (is_delim) pos_next = lrp_pkg::POS_LAST;
                    lrp_pkg::POS_LAST:  if (is_delim) pos_next = lrp_pkg::POS_FIRST;
                    lrp_pkg::POS_FIRST: if (is_delim) pos_next = lrp_pkg::POS_FLAG;
                    lrp_pkg::POS_FLAG:  pos_next = lrp_pkg::POS_DONE;
                    default:            pos_next = pos_reg;
                endcase
            end
        end
    end

    // Datapath and result
    always_comb begin
        len_next   = len_reg;
        last_next  = last_reg;
        first_next = first_reg;
        post_next  = post_reg;
        err_next   = err_reg;
        res_valid  = 1'b0;
        res        = '0;
        if (req_take) begin
            if (req_eol) begin
                res_valid         = 1'b1;
                res.kind          = lrp_pkg::KIND_SUMMARY;
                res.last_article  = last_reg;
                res.first_article = first_reg;
                res.direct_post   = post_reg;
                res.line_status   = (pos_reg == lrp_pkg::POS_NAME ||
                                     pos_reg == lrp_pkg::POS_LAST ||
                                     pos_reg == lrp_pkg::POS_FIRST) ?
                                    lrp_pkg::ST_MISSING : err_reg;
                len_next   = '0;
                last_next  = '0;
                first_next = '0;
                post_next  = 1'b1;
                err_next   = lrp_pkg::ST_OK;
            end else begin
                unique case (pos_reg)
                    lrp_pkg::POS_NAME: begin
                        if (!is_delim && len_reg < LEN_LIMIT) begin
                            len_next      = len_reg + LEN_W'(1);
                            res_valid     = 1'b1;
                            res.kind      = lrp_pkg::KIND_NAME;
                            res.name_byte = req_byte;
                        end
                    end
                    lrp_pkg::POS_LAST, lrp_pkg::POS_FIRST: begin
                        if (!is_delim) begin
                            if (is_digit) begin
                                if (pos_reg == lrp_pkg::POS_LAST) begin
                                    last_next = lrp_pkg::dec_step(last_reg, req_byte[3:0]);
                                end else begin
                                    first_next = lrp_pkg::dec_step(first_reg, req_byte[3:0]);
                                end
                            end else if (err_reg == lrp_pkg::ST_OK) begin
                                err_next = lrp_pkg::ST_NONDIGIT;
                            end
                        end
                    end
                    lrp_pkg::POS_FLAG: begin
                        if ((req_byte == lrp_pkg::CH_EQUALS ||
                             req_byte == lrp_pkg::CH_UPPER_X ||
                             req_byte == lrp_pkg::CH_LOWER_X) &&
                            err_reg == lrp_pkg::ST_OK) begin
                            err_next = lrp_pkg::ST_REJECT;
                        end
                        post_next = !(req_byte == lrp_pkg::CH_UPPER_Y ||
                                      req_byte == lrp_pkg::CH_LOWER_Y);
                    end
                    default: begin
                        post_next = post_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= lrp_pkg::POS_NAME;
            len_reg   <= '0;
            last_reg  <= '0;
            first_reg <= '0;
            post_reg  <= 1'b1;
            err_reg   <= lrp_pkg::ST_OK;
        end else begin
            pos_reg   <= pos_next;
            len_reg   <= len_next;
            last_reg  <= last_next;
            first_reg <= first_next;
            post_reg  <= post_next;
            err_reg   <= err_next;
        end
    end

    a_eol_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (req_take && req_eol) |=> (pos_reg == lrp_pkg::POS_NAME && len_reg == '0 &&
                                   last_reg == '0 && first_reg == '0))
        else $error("line state not cleared after end of line");

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LEN_LIMIT)
        else $error("name length beyond capacity");

    a_nondigit_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (err_reg == lrp_pkg::ST_NONDIGIT) |-> (pos_reg != lrp_pkg::POS_NAME))
        else $error("digit error recorded inside the name field");

endmodule

### rtl/list_reply_line_parser_core.sv
// Top level: group list line parser with registered result and skid stage.
`timescale 1ns / 1ps

// Group list line parser.
// Input channel (s_): one request per line byte. s_tdata[7:0] carries the byte,
// s_tlast marks the end of the line; an end-of-line request carries no byte.
// Result channel (m_): m_tuser = 0 for a group name byte, 1 for the line summary.
// Name bytes are forwarded as they arrive, up to NAME_CAPACITY-1 of them; the
// summary carries both article numbers, the direct-posting flag and a status.
// Bytes that end a field, number digits and the flag produce no result.
// With the receiver ready, a result appears on the m_ side in the cycle
// after its request is taken. Throughput: one request per cycle while
// s_tready is high; each byte is a single small state update, and the widest
// path is the saturating times-ten add of a 31-bit number.
// A skid stage behind the result register holds one result while the receiver
// stalls. s_tready drops only while that stage is full, i.e. while two results
// wait for the receiver, and stays low for as long as the receiver holds off;
// it rises again in the cycle after the receiver takes the older result.
// Reset (aresetn low, synchronous): parser returns to the name field with
// cleared numbers and direct posting set; both result stages are emptied.
module list_reply_line_parser_core #(
    parameter int NAME_CAPACITY = lrp_pkg::NAME_CAPACITY_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] line_byte
    input  logic        s_tlast,   // end_of_line
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [7:0] name_byte, [38:8] last_article,
                                   // [69:39] first_article, [70] direct_post,
                                   // [72:71] line_status, [79:73] zero
    output logic        m_tuser    // result_kind
);

    logic             take;
    logic             res_valid;
    lrp_pkg::result_t res;

    logic             out_valid_reg, out_valid_next;
    lrp_pkg::result_t out_reg, out_next;
    logic             skid_valid_reg, skid_valid_next;
    lrp_pkg::result_t skid_reg, skid_next;

    // Accept whenever the skid stage is free
    assign s_tready = !skid_valid_reg;
    assign take     = s_tvalid && s_tready;

    lrp_parse #(
        .NAME_CAPACITY(NAME_CAPACITY)
    ) u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_take  (take),
        .req_byte  (s_tdata),
        .req_eol   (s_tlast),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result register and skid stage
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg) begin
            // no request taken this cycle; drain the skid stage when possible
            if (!out_valid_reg || m_tready) begin
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (out_valid_reg && !m_tready) begin
            // hold the stalled result; park a new one in the skid stage
            if (res_valid) begin
                skid_valid_next = 1'b1;
                skid_next       = res;
            end
        end else begin
            // result register empty or moving on this cycle
            out_valid_next = res_valid;
            if (res_valid) begin
                out_next = res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {7'b0000000, out_reg.line_status, out_reg.direct_post,
                       out_reg.first_article, out_reg.last_article, out_reg.name_byte};

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage full while result register empty");

    a_summary_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[7:0] == 8'h00))
        else $error("summary carries a name byte");

    a_name_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[79:8] == '0))
        else $error("name result carries summary fields");

endmodule
